@@ hw/rtl/psu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and helpers for the packed sample unpacker.
// ----------------------------------------------------------------------------
package psu_pkg;

   // packing formats held in the sample_format register
   localparam logic [1:0] FMT_PAIR12  = 2'd0;  // two 12-bit samples in 3 bytes
   localparam logic [1:0] FMT_SPLIT10 = 2'd1;  // three 10-bit samples, split last sample
   localparam logic [1:0] FMT_WORD10  = 2'd2;  // three 10-bit samples in a 32-bit word

   // sample position within a packing group
   localparam logic [1:0] SLOT_0 = 2'd0;
   localparam logic [1:0] SLOT_1 = 2'd1;
   localparam logic [1:0] SLOT_2 = 2'd2;

   // register map (word index = paddr[2])
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic        CSR_IDX_FMT  = 1'b0;

   // result queue
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic signed [11:0] sample;
      logic [1:0]         slot;
      logic               last;
   } rsp_type;

   // up to two results produced by one byte, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic signed [11:0] sext10(input logic [9:0] v);
      sext10 = $signed({{2{v[9]}}, v});
   endfunction

endpackage

@@ hw/rtl/psu_unpack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_unpack
// Format register, group phase and held bytes; turns each accepted byte into
// zero, one or two samples for the result queue.
// ----------------------------------------------------------------------------
module psu_unpack (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_we,
   input  logic [1:0]        cfg_fmt,
   input  logic              accept,
   input  psu_pkg::req_type  req,
   output logic [1:0]        fmt,
   output psu_pkg::push_type push
);
   import psu_pkg::*;

   logic [1:0] fmt_ff, fmt_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] ph;
   logic [7:0] b;

   assign fmt = fmt_ff;
   assign b   = req.data_byte;
   assign ph  = req.restart ? 2'd0 : phase_ff;

   always_comb begin
      fmt_in   = cfg_we ? cfg_fmt : fmt_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      push     = '0;
      if (accept) begin
         unique case (fmt_ff)
            FMT_PAIR12: begin
               unique case (ph)
                  2'd1: begin
                     held_in[1]        = b;
                     push.count        = 2'd1;
                     push.first.sample = $signed({b[3:0], held_ff[0]});
                     push.first.slot   = SLOT_0;
                     push.first.last   = 1'b1;
                     phase_in          = 2'd2;
                  end
                  2'd2: begin
                     push.count        = 2'd1;
                     push.first.sample = $signed({held_ff[1][7:4], b});
                     push.first.slot   = SLOT_1;
                     push.first.last   = 1'b1;
                     phase_in          = 2'd0;
                  end
                  default: begin
                     // phase 0, or out of step: start a new group
                     held_in[0] = b;
                     phase_in   = 2'd1;
                  end
               endcase
            end
            FMT_SPLIT10: begin
               unique case (ph)
                  2'd0: held_in[0] = b;
                  2'd1: begin
                     held_in[1]        = b;
                     push.count        = 2'd1;
                     push.first.sample = sext10({b[2:0], held_ff[0][7:1]});
                     push.first.slot   = SLOT_0;
                     push.first.last   = 1'b1;
                  end
                  2'd2: held_in[2] = b;
                  default: begin
                     // last byte: word 1 sample, then the split sample
                     push.count         = 2'd2;
                     push.first.sample  = sext10({b[2:0], held_ff[2][7:1]});
                     push.first.slot    = SLOT_1;
                     push.first.last    = 1'b0;
                     push.second.sample = sext10({b[7:3], held_ff[1][7:3]});
                     push.second.slot   = SLOT_2;
                     push.second.last   = 1'b1;
                  end
               endcase
               phase_in = ph + 2'd1;
            end
            FMT_WORD10: begin
               unique case (ph)
                  2'd0: held_in[0] = b;
                  2'd1: begin
                     held_in[1]        = b;
                     push.count        = 2'd1;
                     push.first.sample = sext10({b[1:0], held_ff[0]});
                     push.first.slot   = SLOT_0;
                     push.first.last   = 1'b1;
                  end
                  2'd2: begin
                     held_in[2]        = b;
                     push.count        = 2'd1;
                     push.first.sample = sext10({b[3:0], held_ff[1][7:2]});
                     push.first.slot   = SLOT_1;
                     push.first.last   = 1'b1;
                  end
                  default: begin
                     push.count        = 2'd1;
                     push.first.sample = sext10({b[5:0], held_ff[2][7:4]});
                     push.first.slot   = SLOT_2;
                     push.first.last   = 1'b1;
                  end
               endcase
               phase_in = ph + 2'd1;
            end
            default: phase_in = 2'd0;  // unused format: byte dropped
         endcase
      end
      if (cfg_we) begin
         phase_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_PAIR12;
         phase_ff   <= 2'd0;
         held_ff[0] <= 8'd0;
         held_ff[1] <= 8'd0;
         held_ff[2] <= 8'd0;
      end else begin
         fmt_ff   <= fmt_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_pair12_phase: assert property (@(posedge clock) disable iff (reset)
      (fmt_ff == FMT_PAIR12) |-> (phase_ff != 2'd3))
      else $error("phase out of step in 12-bit format");

   a_two_only_split: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (fmt_ff == FMT_SPLIT10 && ph == 2'd3))
      else $error("two samples from one byte outside the split format");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (push.count == 2'd0))
      else $error("sample produced without an accepted request");

endmodule

@@ hw/rtl/psu_rsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_rsp_queue
// Small shifting result queue: takes up to two samples a cycle, hands out one.
// Entry 0 is the output register.
// ----------------------------------------------------------------------------
module psu_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  psu_pkg::push_type push,
   output logic              space_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psu_pkg::rsp_type  rsp_data
);
   import psu_pkg::*;

   rsp_type              entry_ff [RSP_DEPTH];
   rsp_type              entry_in [RSP_DEPTH];
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_CNT_W-1:0] base;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[0];
   assign pop       = rsp_valid & rsp_ready;
   assign base      = count_ff - RSP_CNT_W'(pop);
   // room for a two-sample byte whatever the receiver does
   assign space_ok  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign count_in  = base + RSP_CNT_W'(push.count);

   always_comb begin
      for (int i = 0; i < RSP_DEPTH - 1; i++) begin
         entry_in[i] = pop ? entry_ff[i + 1] : entry_ff[i];
      end
      entry_in[RSP_DEPTH - 1] = entry_ff[RSP_DEPTH - 1];
      for (int i = 0; i < RSP_DEPTH; i++) begin
         if (push.count != 2'd0 && base == RSP_CNT_W'(i)) begin
            entry_in[i] = push.first;
         end else if (push.count == 2'd2 && base + RSP_CNT_W'(1) == RSP_CNT_W'(i)) begin
            entry_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("samples pushed without room");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && !pop) |=> (count_ff == $past(count_ff)))
      else $error("queue fill changed without push or pop");

endmodule

@@ hw/rtl/packed_sample_unpacker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sample_unpacker_unit
// Byte-serial unpacker for 12-bit and 10-bit bit-packed signed samples.
//
// Request channel (req_): one raw stream byte per request, plus a restart
// flag that makes the byte the first of a new packing group.
// Result channel (rsp_): sign-extended 12-bit sample, its slot within the
// group, and a last flag on the final sample a byte yields.
// APB-style port: sample_format at byte address 0 picks the packing
// (0: 2x12 bits in 3 bytes, 1: 3x10 bits split over two 16-bit words,
// 2: 3x10 bits in a 32-bit word); writing it restarts the group phase.
// A sample is written to the registered result queue with the byte that completes it.
// Throughput: one byte per cycle, set by a single registered unpack step;
// a four-entry result queue absorbs the two samples from the last byte of
// a split-format group. A stalled receiver fills the queue, and req_ready
// drops once fewer than two entries are free.
// Reset: format 0, phase 0, queue empty.
// ----------------------------------------------------------------------------
module packed_sample_unpacker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  psu_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output psu_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psu_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [psu_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [psu_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import psu_pkg::*;

   logic     accept;
   logic     cfg_we;
   logic     space_ok;
   logic     csr_idx;
   logic [1:0] fmt;
   push_type push;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[2];
   assign cfg_we    = psel & penable & pwrite & (csr_idx == CSR_IDX_FMT);
   assign prdata    = (csr_idx == CSR_IDX_FMT) ? {{(CSR_DATA_W - 2){1'b0}}, fmt} : '0;
   assign req_ready = space_ok;
   assign accept    = req_valid & req_ready;

   psu_unpack u_unpack (
      .clock   (clock),
      .reset   (reset),
      .cfg_we  (cfg_we),
      .cfg_fmt (pwdata[1:0]),
      .accept  (accept),
      .req     (req_data),
      .fmt     (fmt),
      .push    (push)
   );

   psu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
